// ===== hw/rtl/ssk_pkg.sv =====
// shared types and constants of the shell sort key/index block
`default_nettype none

package ssk_pkg;

   localparam int TAG_BITS      = 6;
   localparam int KEY_PORT_BITS = 32;
   localparam int KEY_EXT_BITS  = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PASS,
      ST_CHECK,
      ST_CMP,
      ST_WR_LO,
      ST_WR_HI,
      ST_EMIT_RD,
      ST_EMIT_HOLD
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ssk_ifs.sv =====
// valid/ready channel interfaces for the request and response words
`default_nettype none

interface ssk_req_if
   import ssk_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [KEY_PORT_BITS-1:0] key;
   logic [TAG_BITS-1:0]      tag;
   logic                     last_item;

   modport source (output valid, output key, output tag, output last_item, input ready);
   modport sink   (input valid, input key, input tag, input last_item, output ready);
endinterface

interface ssk_rsp_if
   import ssk_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [KEY_PORT_BITS-1:0] sorted_key;
   logic [TAG_BITS-1:0]      sorted_tag;
   logic                     end_of_run;
   logic                     overflow;

   modport source (output valid, output sorted_key, output sorted_tag, output end_of_run,
                   output overflow, input ready);
   modport sink   (input valid, input sorted_key, input sorted_tag, input end_of_run,
                   input overflow, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ssk_store.sv =====
// key/tag store: one write port, two registered read ports
`default_nettype none

module ssk_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 38
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/shell_sort_key_index.sv =====
// top level of the shell sort key/index block: load, gapped exchange sort, emit
//
// usage
//   req_ch carries one key/tag word per handshake; the word with last_item set
//   closes the set. words are taken one per cycle while the block is idle.
//   once the set is closed the block sorts it in place (ascending key order)
//   and then sends one rsp_ch word per stored pair, end_of_run on the final
//   one, overflow on all of them when more than MAX_ITEMS words arrived.
// sequencing
//   sorting shares one comparator and a two-read, one-write store: a compare
//   reads both pairs (ST_CHECK) and compares them (ST_CMP), a swap writes them
//   back (ST_WR_LO, ST_WR_HI), and each pass adds a gap update (ST_PASS) and a
//   closing bound check (ST_CHECK). emitting reads each word (ST_EMIT_RD) and
//   holds it (ST_EMIT_HOLD) until rsp_ch takes it.
// reset
//   synchronous active-high reset empties the set and returns to idle; the
//   store contents are not cleared and are never read before being written.
// stalls
//   the response word sits in an output register until taken; while it waits
//   no new request is accepted (req_ch.ready is low outside idle).
`default_nettype none

module shell_sort_key_index
   import ssk_pkg::*;
#(
   parameter int MAX_ITEMS = 64,
   parameter int KEY_BITS  = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   ssk_req_if.sink   req_ch,
   ssk_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(MAX_ITEMS);       // store address bits
   localparam int CW = $clog2(MAX_ITEMS + 1);   // count bits, holds MAX_ITEMS
   localparam int EW = KEY_BITS + TAG_BITS;     // store word: {key, tag}

   // control registers
   state_type        state_ff, state_in;
   logic [CW-1:0]    fill_ff, fill_in;       // pairs stored so far
   logic             ovf_ff, ovf_in;         // set saw a dropped pair
   logic [CW-1:0]    cnt_ff, cnt_in;         // pairs in the closed set
   logic [CW-1:0]    gap_ff, gap_in;
   logic [CW-1:0]    idx_ff, idx_in;         // compare / emit position
   logic             swapped_ff, swapped_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // store port signals
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [EW-1:0]    wr_data;
   logic             rd_en;
   logic [EW-1:0]    rd_data_a;
   logic [EW-1:0]    rd_data_b;

   // datapath helpers
   logic [CW:0]           pair_sum;          // idx + gap, one bit of headroom
   logic [CW:0]           gap_half;
   logic [CW-1:0]         idx_inc;
   logic                  store_room;
   logic                  key_less;
   logic                  last_emit;
   logic [KEY_EXT_BITS-1:0] req_key_ext;
   logic [KEY_EXT_BITS-1:0] rsp_key_ext;
   logic [EW-1:0]         req_word;

   assign pair_sum    = {1'b0, idx_ff} + {1'b0, gap_ff};
   assign gap_half    = ({1'b0, gap_ff} + (CW+1)'(1)) >> 1;
   assign idx_inc     = idx_ff + CW'(1);
   assign store_room  = fill_ff < CW'(MAX_ITEMS);
   assign last_emit   = idx_inc == cnt_ff;

   // the shared comparator: later key strictly below earlier key
   assign key_less    = rd_data_b[EW-1:TAG_BITS] < rd_data_a[EW-1:TAG_BITS];

   // keys are kept to KEY_BITS on the way in and cut to the port width on the way out
   assign req_key_ext = KEY_EXT_BITS'(req_ch.key);
   assign req_word    = {req_key_ext[KEY_BITS-1:0], req_ch.tag};
   assign rsp_key_ext = KEY_EXT_BITS'(rd_data_a[EW-1:TAG_BITS]);

   ssk_store #(
      .DEPTH (MAX_ITEMS),
      .WIDTH (EW)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (idx_ff[AW-1:0]),
      .rd_addr_b (pair_sum[AW-1:0]),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sequencer datapath registers, only meaningful once a set is closed
   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      gap_ff     <= gap_in;
      idx_ff     <= idx_in;
      swapped_ff <= swapped_in;
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      cnt_in       = cnt_ff;
      gap_in       = gap_ff;
      idx_in       = idx_ff;
      swapped_in   = swapped_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = rd_data_b;
      rd_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // append the word, or drop it and flag once the store is full
            wr_addr = fill_ff[AW-1:0];
            wr_data = req_word;
            if (req_ch.valid) begin
               if (store_room) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + CW'(1);
               end else begin
                  ovf_in  = 1'b1;
               end
               if (req_ch.last_item) begin
                  cnt_in     = store_room ? fill_ff + CW'(1) : fill_ff;
                  gap_in     = store_room ? fill_ff + CW'(1) : fill_ff;
                  swapped_in = 1'b1;
                  state_in   = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            // another pass while the gap is still wide or the last pass moved something
            idx_in = '0;
            if (swapped_ff || gap_ff > CW'(1)) begin
               swapped_in = 1'b0;
               gap_in     = gap_half[CW-1:0];
               state_in   = ST_CHECK;
            end else begin
               state_in   = ST_EMIT_RD;
            end
         end
         ST_CHECK: begin
            if (pair_sum < {1'b0, cnt_ff}) begin
               rd_en    = 1'b1;
               state_in = ST_CMP;
            end else begin
               state_in = ST_PASS;
            end
         end
         ST_CMP: begin
            if (key_less) begin
               swapped_in = 1'b1;
               state_in   = ST_WR_LO;
            end else begin
               idx_in     = idx_inc;
               state_in   = ST_CHECK;
            end
         end
         ST_WR_LO: begin
            // later pair moves down to the earlier slot
            wr_en    = 1'b1;
            wr_addr  = idx_ff[AW-1:0];
            wr_data  = rd_data_b;
            state_in = ST_WR_HI;
         end
         ST_WR_HI: begin
            wr_en    = 1'b1;
            wr_addr  = pair_sum[AW-1:0];
            wr_data  = rd_data_a;
            idx_in   = idx_inc;
            state_in = ST_CHECK;
         end
         ST_EMIT_RD: begin
            // read data lands in the port register together with valid
            rd_en        = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               if (last_emit) begin
                  fill_in  = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_inc;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ch.ready      = state_ff == ST_IDLE;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sorted_key = rsp_key_ext[KEY_PORT_BITS-1:0];
   assign rsp_ch.sorted_tag = rd_data_a[TAG_BITS-1:0];
   assign rsp_ch.end_of_run = last_emit;
   assign rsp_ch.overflow   = ovf_ff;

`ifndef SYNTH
   // a compare only ever looks at pairs inside the closed set
   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP |-> pair_sum < {1'b0, cnt_ff})
      else $error("compare beyond closed set");

   // a swap always writes both halves back to back
   a_swap_pair: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WR_LO |=> state_ff == ST_WR_HI)
      else $error("swap left half done");

   // the gap never collapses to zero while sorting
   a_gap_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |-> gap_ff != '0)
      else $error("zero gap in sort");

   // the fill count never passes the store depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(MAX_ITEMS))
      else $error("fill count past store depth");

   // a response word is only offered while the emitter waits for it
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_EMIT_HOLD)
      else $error("response valid outside emit");
`endif

endmodule

`default_nettype wire
